>>> rtl/core/nlsp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nlsp_pkg
// Shared types and constants for the NACK list sort-and-pack block.
// ----------------------------------------------------------------------------
package nlsp_pkg;

   // Span of one BLP mask above its PID.
   localparam int BLP_SPAN = 16;

   // Depth of the command queue between the front end and the sequencer.
   localparam int QUEUE_DEPTH = 2;

   typedef enum logic [1:0] {
      OP_INSERT = 2'd0,
      OP_PAIR   = 2'd1,
      OP_CLEAR  = 2'd2,
      OP_PACK   = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      KIND_STATUS = 2'd0,
      KIND_CHUNK  = 2'd1,
      KIND_EMPTY  = 2'd2
   } kind_type;

   typedef enum logic [3:0] {
      BK_IDLE,
      BK_INS_START,
      BK_INS_RD,
      BK_INS_EV,
      BK_INS_LAST,
      BK_PAIR_NEXT,
      BK_PACK_RD,
      BK_PACK_EV,
      BK_PACK_END,
      BK_STATUS
   } back_state_type;

   typedef struct packed {
      op_type      op;
      logic [15:0] seq_number;
      logic [15:0] loss_mask;
   } cmd_type;

   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } queue_head_type;

endpackage

>>> rtl/core/nlsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nlsp_req_if / nlsp_rsp_if
// Valid/ready channels for commands into and results out of the block.
// ----------------------------------------------------------------------------
interface nlsp_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  operation;
   logic [15:0] seq_number;
   logic [15:0] loss_mask;

   modport source (output valid, output operation, output seq_number,
                   output loss_mask, input ready);
   modport sink   (input valid, input operation, input seq_number,
                   input loss_mask, output ready);
endinterface

interface nlsp_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  result_kind;
   logic [15:0] chunk_pid;
   logic [15:0] chunk_mask;
   logic [6:0]  entry_count;
   logic        overflowed;
   logic        last_result;

   modport source (output valid, output result_kind, output chunk_pid,
                   output chunk_mask, output entry_count, output overflowed,
                   output last_result, input ready);
   modport sink   (input valid, input result_kind, input chunk_pid,
                   input chunk_mask, input entry_count, input overflowed,
                   input last_result, output ready);
endinterface

>>> rtl/core/nack_list_sort_and_pack.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nack_list_sort_and_pack
// Sorted list of missing RTP sequence numbers with generic NACK PID/BLP
// packing.
// ----------------------------------------------------------------------------
// The block keeps up to LIST_CAPACITY missing sequence numbers in ascending
// order and packs them into PID/BLP chunks on request. Commands enter through
// a two-deep queue, so up to two transfers are taken while earlier work is
// still running. Work proceeds one command at a time through the list RAM,
// which is read and then compared entry by entry. A single insert walks down
// from the top of the list, moving each stored entry greater than the new
// number up one place. A pair insert runs one such insert for the PID and for
// each set mask bit, scanning the mask bit by bit, so up to 17 inserts. A
// clear resets the entry count and the overflow flag. A pack reads each stored
// entry in order and emits one result transfer for every chunk, the last
// one flagged by last_result; a pack of an empty list gives one result of kind
// "empty". Every other command gives one status transfer. Results sit in an
// output register; the walk pauses when it must emit while that register is
// still full. An insert into a full list drops the number and raises the
// overflow flag until the next clear. The list is not cleared by a pack and
// needs no clearing pass after reset.
module nack_list_sort_and_pack #(
   parameter int LIST_CAPACITY = 64
) (
   input logic        clock,
   input logic        reset,
   nlsp_req_if.sink   req_if,
   nlsp_rsp_if.source rsp_if
);

   // Head of the command queue and the sequencer's pop strobe.
   nlsp_pkg::queue_head_type head;
   logic                     take;

   nlsp_front u_front (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .head   (head),
      .take   (take)
   );

   nlsp_back #(
      .LIST_CAPACITY (LIST_CAPACITY)
   ) u_back (
      .clock  (clock),
      .reset  (reset),
      .head   (head),
      .take   (take),
      .rsp_if (rsp_if)
   );

endmodule

>>> rtl/core/nlsp_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nlsp_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module nlsp_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/core/nlsp_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nlsp_front
// Accepts commands, decodes the operation and holds them in a short queue.
// ----------------------------------------------------------------------------
module nlsp_front (
   input  logic                    clock,
   input  logic                    reset,
   nlsp_req_if.sink                req_if,
   output nlsp_pkg::queue_head_type head,
   input  logic                    take
);

   nlsp_pkg::cmd_type cmd_ff [nlsp_pkg::QUEUE_DEPTH];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push;
   logic       pop;

   assign req_if.ready = (count_ff != 2'(nlsp_pkg::QUEUE_DEPTH));
   assign push = req_if.valid && req_if.ready;
   assign pop  = take && (count_ff != 2'd0);

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop  ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         cmd_ff[wr_ptr_ff] <= '{op:         nlsp_pkg::op_type'(req_if.operation),
                                seq_number: req_if.seq_number,
                                loss_mask:  req_if.loss_mask};
      end
   end

   assign head.valid = (count_ff != 2'd0);
   assign head.cmd   = cmd_ff[rd_ptr_ff];

endmodule

>>> rtl/core/nlsp_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nlsp_back
// Sequencer that keeps the sorted list in RAM, runs inserts, clears and
// packs, and drives the registered result channel.
// ----------------------------------------------------------------------------
module nlsp_back #(
   parameter int LIST_CAPACITY = 64
) (
   input  logic                    clock,
   input  logic                    reset,
   input  nlsp_pkg::queue_head_type head,
   output logic                    take,
   nlsp_rsp_if.source              rsp_if
);

   localparam int ADDR_W = $clog2(LIST_CAPACITY);
   localparam int CNT_W  = $clog2(LIST_CAPACITY + 1);

   nlsp_pkg::back_state_type state_ff, state_in;
   logic [CNT_W-1:0]  total_ff, total_in;
   logic              ovf_ff, ovf_in;
   logic [15:0]       val_ff, val_in;
   logic [15:0]       base_ff, base_in;
   logic [15:0]       bits_ff, bits_in;
   logic [4:0]        k_ff, k_in;
   logic [ADDR_W-1:0] idx_ff, idx_in;
   logic [15:0]       pid_ff, pid_in;
   logic [15:0]       pmask_ff, pmask_in;
   nlsp_pkg::kind_type kind_ff, kind_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [1:0]  rsp_kind_ff;
   logic [15:0] rsp_pid_ff;
   logic [15:0] rsp_mask_ff;
   logic [6:0]  rsp_count_ff;
   logic        rsp_ovf_ff;
   logic        rsp_last_ff;

   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   logic [15:0]       wr_data;
   logic              rd_en;
   logic [ADDR_W-1:0] rd_addr;
   logic [15:0]       rd_data;

   logic               out_free;
   logic               emit;
   nlsp_pkg::kind_type emit_kind;
   logic [15:0]        emit_pid;
   logic [15:0]        emit_mask;
   logic               emit_last;
   logic [15:0]        diff;
   logic               at_end;
   logic               list_full;

   nlsp_ram #(
      .WIDTH (16),
      .DEPTH (LIST_CAPACITY)
   ) u_list_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign out_free  = !rsp_valid_ff || rsp_if.ready;
   assign diff      = rd_data - pid_ff;
   assign at_end    = (CNT_W'(idx_ff) + CNT_W'(1)) == total_ff;
   assign list_full = (total_ff == CNT_W'(LIST_CAPACITY));

   always_comb begin
      state_in  = state_ff;
      total_in  = total_ff;
      ovf_in    = ovf_ff;
      val_in    = val_ff;
      base_in   = base_ff;
      bits_in   = bits_ff;
      k_in      = k_ff;
      idx_in    = idx_ff;
      pid_in    = pid_ff;
      pmask_in  = pmask_ff;
      kind_in   = kind_ff;
      take      = 1'b0;
      wr_en     = 1'b0;
      wr_addr   = idx_ff + ADDR_W'(1);
      wr_data   = val_ff;
      rd_en     = 1'b0;
      rd_addr   = idx_ff;
      emit      = 1'b0;
      emit_kind = nlsp_pkg::KIND_CHUNK;
      emit_pid  = pid_ff;
      emit_mask = pmask_ff;
      emit_last = 1'b0;

      case (state_ff)
         nlsp_pkg::BK_IDLE: begin
            if (head.valid) begin
               take    = 1'b1;
               val_in  = head.cmd.seq_number;
               base_in = head.cmd.seq_number;
               k_in    = 5'd0;
               kind_in = nlsp_pkg::KIND_STATUS;
               case (head.cmd.op)
                  nlsp_pkg::OP_INSERT: begin
                     bits_in  = 16'd0;
                     state_in = nlsp_pkg::BK_INS_START;
                  end
                  nlsp_pkg::OP_PAIR: begin
                     bits_in  = head.cmd.loss_mask;
                     state_in = nlsp_pkg::BK_INS_START;
                  end
                  nlsp_pkg::OP_CLEAR: begin
                     total_in = '0;
                     ovf_in   = 1'b0;
                     state_in = nlsp_pkg::BK_STATUS;
                  end
                  default: begin
                     idx_in = '0;
                     if (total_ff == '0) begin
                        kind_in  = nlsp_pkg::KIND_EMPTY;
                        state_in = nlsp_pkg::BK_STATUS;
                     end else begin
                        state_in = nlsp_pkg::BK_PACK_RD;
                     end
                  end
               endcase
            end
         end

         nlsp_pkg::BK_INS_START: begin
            if (list_full) begin
               ovf_in   = 1'b1;
               state_in = nlsp_pkg::BK_PAIR_NEXT;
            end else if (total_ff == '0) begin
               wr_en    = 1'b1;
               wr_addr  = '0;
               total_in = total_ff + CNT_W'(1);
               state_in = nlsp_pkg::BK_PAIR_NEXT;
            end else begin
               idx_in   = ADDR_W'(total_ff - CNT_W'(1));
               state_in = nlsp_pkg::BK_INS_RD;
            end
         end

         nlsp_pkg::BK_INS_RD: begin
            rd_en    = 1'b1;
            state_in = nlsp_pkg::BK_INS_EV;
         end

         nlsp_pkg::BK_INS_EV: begin
            wr_en = 1'b1;
            if (rd_data > val_ff) begin
               // Move the larger entry up one place and keep looking down.
               wr_data = rd_data;
               if (idx_ff == '0) begin
                  state_in = nlsp_pkg::BK_INS_LAST;
               end else begin
                  idx_in   = idx_ff - ADDR_W'(1);
                  state_in = nlsp_pkg::BK_INS_RD;
               end
            end else begin
               total_in = total_ff + CNT_W'(1);
               state_in = nlsp_pkg::BK_PAIR_NEXT;
            end
         end

         nlsp_pkg::BK_INS_LAST: begin
            wr_en    = 1'b1;
            wr_addr  = '0;
            total_in = total_ff + CNT_W'(1);
            state_in = nlsp_pkg::BK_PAIR_NEXT;
         end

         nlsp_pkg::BK_PAIR_NEXT: begin
            if (bits_ff == 16'd0) begin
               state_in = nlsp_pkg::BK_STATUS;
            end else begin
               bits_in = bits_ff >> 1;
               k_in    = k_ff + 5'd1;
               if (bits_ff[0]) begin
                  val_in   = base_ff + 16'(k_ff) + 16'd1;
                  state_in = nlsp_pkg::BK_INS_START;
               end
            end
         end

         nlsp_pkg::BK_PACK_RD: begin
            rd_en    = 1'b1;
            state_in = nlsp_pkg::BK_PACK_EV;
         end

         nlsp_pkg::BK_PACK_EV: begin
            if (idx_ff == '0) begin
               pid_in   = rd_data;
               pmask_in = 16'd0;
               state_in = at_end ? nlsp_pkg::BK_PACK_END : nlsp_pkg::BK_PACK_RD;
               idx_in   = idx_ff + ADDR_W'(!at_end);
            end else if (rd_data <= pid_ff) begin
               state_in = at_end ? nlsp_pkg::BK_PACK_END : nlsp_pkg::BK_PACK_RD;
               idx_in   = idx_ff + ADDR_W'(!at_end);
            end else if (diff > 16'(nlsp_pkg::BLP_SPAN)) begin
               // Gap too wide: close this chunk once the output can take it.
               if (out_free) begin
                  emit     = 1'b1;
                  pid_in   = rd_data;
                  pmask_in = 16'd0;
                  state_in = at_end ? nlsp_pkg::BK_PACK_END : nlsp_pkg::BK_PACK_RD;
                  idx_in   = idx_ff + ADDR_W'(!at_end);
               end
            end else begin
               pmask_in = pmask_ff | (16'd1 << 4'(diff - 16'd1));
               state_in = at_end ? nlsp_pkg::BK_PACK_END : nlsp_pkg::BK_PACK_RD;
               idx_in   = idx_ff + ADDR_W'(!at_end);
            end
         end

         nlsp_pkg::BK_PACK_END: begin
            if (out_free) begin
               emit      = 1'b1;
               emit_last = 1'b1;
               state_in  = nlsp_pkg::BK_IDLE;
            end
         end

         nlsp_pkg::BK_STATUS: begin
            emit_kind = kind_ff;
            emit_pid  = 16'd0;
            emit_mask = 16'd0;
            emit_last = 1'b1;
            if (out_free) begin
               emit     = 1'b1;
               state_in = nlsp_pkg::BK_IDLE;
            end
         end

         default: begin
            state_in = nlsp_pkg::BK_IDLE;
         end
      endcase
   end

   always_comb begin
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= nlsp_pkg::BK_IDLE;
         total_ff     <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         total_ff     <= total_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      val_ff   <= val_in;
      base_ff  <= base_in;
      bits_ff  <= bits_in;
      k_ff     <= k_in;
      idx_ff   <= idx_in;
      pid_ff   <= pid_in;
      pmask_ff <= pmask_in;
      kind_ff  <= kind_in;
      if (emit) begin
         rsp_kind_ff  <= emit_kind;
         rsp_pid_ff   <= emit_pid;
         rsp_mask_ff  <= emit_mask;
         rsp_count_ff <= 7'(total_ff);
         rsp_ovf_ff   <= ovf_ff;
         rsp_last_ff  <= emit_last;
      end
   end

   assign rsp_if.valid       = rsp_valid_ff;
   assign rsp_if.result_kind = rsp_kind_ff;
   assign rsp_if.chunk_pid   = rsp_pid_ff;
   assign rsp_if.chunk_mask  = rsp_mask_ff;
   assign rsp_if.entry_count = rsp_count_ff;
   assign rsp_if.overflowed  = rsp_ovf_ff;
   assign rsp_if.last_result = rsp_last_ff;

endmodule

>>> rtl/core/nlsp_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nlsp_checker
// Port-level assertions for the NACK list block, bound to the top level.
// ----------------------------------------------------------------------------
module nlsp_checker #(
   parameter int LIST_CAPACITY = 64
) (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [1:0]  result_kind,
   input logic [15:0] chunk_pid,
   input logic [15:0] chunk_mask,
   input logic [6:0]  entry_count,
   input logic        last_result
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(result_kind) &&
      $stable(chunk_pid) && $stable(chunk_mask) && $stable(last_result))
      else $error("result changed while stalled");

   a_single_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && result_kind != nlsp_pkg::KIND_CHUNK |-> last_result)
      else $error("status result not marked last");

   a_status_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && result_kind != nlsp_pkg::KIND_CHUNK |->
      chunk_pid == 16'd0 && chunk_mask == 16'd0)
      else $error("status result carries chunk data");

   a_empty_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && result_kind == nlsp_pkg::KIND_EMPTY |-> entry_count == 7'd0)
      else $error("empty pack with entries held");

   a_count_cap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> entry_count <= 7'(LIST_CAPACITY))
      else $error("entry count above capacity");

endmodule

bind nack_list_sort_and_pack nlsp_checker #(
   .LIST_CAPACITY (LIST_CAPACITY)
) u_nlsp_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_if.valid),
   .rsp_ready   (rsp_if.ready),
   .result_kind (rsp_if.result_kind),
   .chunk_pid   (rsp_if.chunk_pid),
   .chunk_mask  (rsp_if.chunk_mask),
   .entry_count (rsp_if.entry_count),
   .last_result (rsp_if.last_result)
);

>>> test/nack_list_sort_and_pack_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nack_list_sort_and_pack_test
// Self-checking bench for the sorted NACK list and its PID/BLP packing.
// ----------------------------------------------------------------------------
// A short table of directed commands runs first. It covers an empty pack, the
// field extremes, duplicates, a pair that wraps past 65535, a full list with
// dropped numbers, and a clear that resets the overflow flag. A random phase
// follows. Most numbers fall in a moving window, so packs build real BLP
// masks. Every accepted command goes through a behavioral copy of the list,
// and each result transfer is compared field by field with the oldest
// expected result. Both channels pause at random.
// ----------------------------------------------------------------------------
module nack_list_sort_and_pack_test;

   localparam int LIST_CAPACITY = 64;
   localparam int RANDOM_ITEMS  = 160;
   // The limit only catches a hung run: a pair insert into a nearly full list
   // walks the list once per inserted number, and a pack emits at most 64
   // results, each of which may wait out a random stall.
   localparam int CYCLE_LIMIT   = 5_000_000;
   // Every command gives at least one result, so once the last one is in,
   // only a short quiet period is needed to catch stray extra transfers.
   localparam int DRAIN_CYCLES  = 40;

   typedef struct packed {
      nlsp_pkg::kind_type kind;
      logic [15:0]        pid;
      logic [15:0]        mask;
      logic [6:0]         count;
      logic               overflowed;
      logic               last;
   } nack_result_type;

   // One row of the directed table. When known_answer is set, the single
   // result of the row is written out here: its kind, the list size that
   // follows it and the overflow flag. The PID and mask are zero and the
   // result is the last of its command.
   typedef struct packed {
      nlsp_pkg::op_type   op;
      logic [15:0]        seq_number;
      logic [15:0]        loss_mask;
      logic               known_answer;
      nlsp_pkg::kind_type kind;
      logic [6:0]         count;
      logic               overflowed;
   } stim_row_type;

   localparam int DIRECTED_ROWS = 23;

   stim_row_type directed_rows [DIRECTED_ROWS] = '{
      // A pack right after reset finds an empty list.
      '{nlsp_pkg::OP_PACK,   16'h0000, 16'h0000, 1'b1, nlsp_pkg::KIND_EMPTY,  7'd0,  1'b0},
      // A clear ignores its operands.
      '{nlsp_pkg::OP_CLEAR,  16'hFFFF, 16'hFFFF, 1'b1, nlsp_pkg::KIND_STATUS, 7'd0,  1'b0},
      '{nlsp_pkg::OP_INSERT, 16'h0000, 16'h0000, 1'b1, nlsp_pkg::KIND_STATUS, 7'd1,  1'b0},
      '{nlsp_pkg::OP_INSERT, 16'hFFFF, 16'hFFFF, 1'b1, nlsp_pkg::KIND_STATUS, 7'd2,  1'b0},
      '{nlsp_pkg::OP_PACK,   16'h0000, 16'h0000, 1'b0, nlsp_pkg::KIND_STATUS, 7'd0,  1'b0},
      // Duplicate of the lowest entry, then numbers just inside and just
      // outside one BLP span above it.
      '{nlsp_pkg::OP_INSERT, 16'h0000, 16'h0000, 1'b1, nlsp_pkg::KIND_STATUS, 7'd3,  1'b0},
      '{nlsp_pkg::OP_INSERT, 16'd16,   16'h0000, 1'b1, nlsp_pkg::KIND_STATUS, 7'd4,  1'b0},
      '{nlsp_pkg::OP_INSERT, 16'd17,   16'h0000, 1'b1, nlsp_pkg::KIND_STATUS, 7'd5,  1'b0},
      '{nlsp_pkg::OP_PACK,   16'h0000, 16'h0000, 1'b0, nlsp_pkg::KIND_STATUS, 7'd0,  1'b0},
      // A full mask whose members wrap past 65535 to the bottom of the list.
      '{nlsp_pkg::OP_PAIR,   16'hFFFA, 16'hFFFF, 1'b1, nlsp_pkg::KIND_STATUS, 7'd22, 1'b0},
      '{nlsp_pkg::OP_PAIR,   16'h1234, 16'h0000, 1'b1, nlsp_pkg::KIND_STATUS, 7'd23, 1'b0},
      '{nlsp_pkg::OP_PACK,   16'h0000, 16'h0000, 1'b0, nlsp_pkg::KIND_STATUS, 7'd0,  1'b0},
      '{nlsp_pkg::OP_CLEAR,  16'h0000, 16'h0000, 1'b1, nlsp_pkg::KIND_STATUS, 7'd0,  1'b0},
      // Fill the list to exactly its capacity.
      '{nlsp_pkg::OP_PAIR,   16'd100,  16'hFFFF, 1'b1, nlsp_pkg::KIND_STATUS, 7'd17, 1'b0},
      '{nlsp_pkg::OP_PAIR,   16'd200,  16'hFFFF, 1'b1, nlsp_pkg::KIND_STATUS, 7'd34, 1'b0},
      '{nlsp_pkg::OP_PAIR,   16'd300,  16'hFFFF, 1'b1, nlsp_pkg::KIND_STATUS, 7'd51, 1'b0},
      '{nlsp_pkg::OP_PAIR,   16'd400,  16'h0FFF, 1'b1, nlsp_pkg::KIND_STATUS, 7'd64, 1'b0},
      // The list is full: the number is dropped and the flag rises, and a
      // pair loses all of its numbers.
      '{nlsp_pkg::OP_INSERT, 16'd5,    16'h0000, 1'b1, nlsp_pkg::KIND_STATUS, 7'd64, 1'b1},
      '{nlsp_pkg::OP_PAIR,   16'd500,  16'h8001, 1'b1, nlsp_pkg::KIND_STATUS, 7'd64, 1'b1},
      '{nlsp_pkg::OP_PACK,   16'h0000, 16'h0000, 1'b0, nlsp_pkg::KIND_STATUS, 7'd0,  1'b0},
      '{nlsp_pkg::OP_CLEAR,  16'h5A5A, 16'hA5A5, 1'b1, nlsp_pkg::KIND_STATUS, 7'd0,  1'b0},
      '{nlsp_pkg::OP_PACK,   16'hFFFF, 16'hFFFF, 1'b1, nlsp_pkg::KIND_EMPTY,  7'd0,  1'b0},
      '{nlsp_pkg::OP_INSERT, 16'd7,    16'h0000, 1'b1, nlsp_pkg::KIND_STATUS, 7'd1,  1'b0}
   };

   logic clock = 1'b0;
   logic reset;

   nlsp_req_if req_bus ();
   nlsp_rsp_if rsp_bus ();

   nack_list_sort_and_pack #(
      .LIST_CAPACITY (LIST_CAPACITY)
   ) u_top (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_bus),
      .rsp_if (rsp_bus)
   );

   always #4 clock = ~clock;

   // Behavioral copy of the list, kept in step with accepted commands.
   logic [15:0]     held_numbers [LIST_CAPACITY];
   int unsigned     held_total = 0;
   bit              numbers_dropped = 1'b0;
   nack_result_type expected_results [$];

   int  mismatch_count = 0;
   int  cycle_count = 0;
   // While set, neither side pauses, so back-to-back transfers also occur.
   bit  steady_run = 1'b0;

   function automatic int pick_gap();
      int roll;
      if (steady_run)
         return 0;
      roll = $urandom_range(0, 99);
      if (roll < 60)
         return 0;
      if (roll < 92)
         return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // A new number goes after any equal ones; a full list drops it.
   function automatic void add_missing(input logic [15:0] value);
      int unsigned slot;
      if (held_total >= LIST_CAPACITY) begin
         numbers_dropped = 1'b1;
         return;
      end
      slot = held_total;
      while (slot > 0 && held_numbers[slot - 1] > value) begin
         held_numbers[slot] = held_numbers[slot - 1];
         slot--;
      end
      held_numbers[slot] = value;
      held_total++;
   endfunction

   function automatic void queue_result(input bit record, input nlsp_pkg::kind_type kind,
                                        input logic [15:0] pid, input logic [15:0] mask,
                                        input logic last);
      if (record)
         expected_results.push_back('{kind, pid, mask, 7'(held_total), numbers_dropped,
                                      last});
   endfunction

   // Applies one command to the list and, when record is set, queues the
   // results it must produce.
   function automatic void predict_command(input nlsp_pkg::op_type op,
                                           input logic [15:0] seq_number,
                                           input logic [15:0] loss_mask, input bit record);
      logic [15:0] pid;
      logic [15:0] blp;
      int unsigned distance;
      case (op)
         nlsp_pkg::OP_INSERT: begin
            add_missing(seq_number);
         end
         nlsp_pkg::OP_PAIR: begin
            add_missing(seq_number);
            for (int k = 0; k < nlsp_pkg::BLP_SPAN; k++)
               if (loss_mask[k])
                  add_missing(seq_number + 16'(k + 1));
         end
         nlsp_pkg::OP_CLEAR: begin
            held_total = 0;
            numbers_dropped = 1'b0;
         end
         default: begin
            if (held_total == 0) begin
               queue_result(record, nlsp_pkg::KIND_EMPTY, 16'd0, 16'd0, 1'b1);
            end else begin
               // Plain numeric order, no wraparound: entries equal to the
               // PID are skipped, and a gap wider than one span closes the
               // chunk and opens the next one.
               pid = held_numbers[0];
               blp = 16'd0;
               for (int i = 1; i < held_total; i++) begin
                  if (held_numbers[i] > pid) begin
                     distance = held_numbers[i] - pid;
                     if (distance > nlsp_pkg::BLP_SPAN) begin
                        queue_result(record, nlsp_pkg::KIND_CHUNK, pid, blp, 1'b0);
                        pid = held_numbers[i];
                        blp = 16'd0;
                     end else begin
                        blp[distance - 1] = 1'b1;
                     end
                  end
               end
               queue_result(record, nlsp_pkg::KIND_CHUNK, pid, blp, 1'b1);
            end
            return;
         end
      endcase
      queue_result(record, nlsp_pkg::KIND_STATUS, 16'd0, 16'd0, 1'b1);
   endfunction

   task automatic report_mismatch(input string what);
      $display("MISMATCH cycle %0d: %s", cycle_count, what);
      mismatch_count++;
   endtask

   // Presents one command after a random pause and waits for its transfer.
   // When valid stays high from one command to the next, it gets a single
   // assignment in that time step.
   task automatic send_command(input nlsp_pkg::op_type op, input logic [15:0] seq_number,
                               input logic [15:0] loss_mask, input bit known_answer,
                               input nack_result_type answer);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid      <= 1'b1;
      req_bus.operation  <= op;
      req_bus.seq_number <= seq_number;
      req_bus.loss_mask  <= loss_mask;
      @(posedge clock);
      while (!req_bus.ready)
         @(posedge clock);
      // The transfer took place at this edge.
      predict_command(op, seq_number, loss_mask, !known_answer);
      if (known_answer)
         expected_results.push_back(answer);
   endtask

   // Result side: checks each transfer and then decides how long to hold
   // ready low before the next one.
   initial begin : result_monitor
      int stall;
      nack_result_type want;
      stall = 0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_bus.valid && rsp_bus.ready) begin
            if (expected_results.size() == 0) begin
               report_mismatch($sformatf("result with nothing expected (kind %0d pid %0d)",
                                         rsp_bus.result_kind, rsp_bus.chunk_pid));
            end else begin
               want = expected_results.pop_front();
               if (rsp_bus.result_kind !== want.kind)
                  report_mismatch($sformatf("result_kind %0d, expected %0d",
                                            rsp_bus.result_kind, want.kind));
               if (rsp_bus.chunk_pid !== want.pid)
                  report_mismatch($sformatf("chunk_pid %0d, expected %0d",
                                            rsp_bus.chunk_pid, want.pid));
               if (rsp_bus.chunk_mask !== want.mask)
                  report_mismatch($sformatf("chunk_mask %h, expected %h",
                                            rsp_bus.chunk_mask, want.mask));
               if (rsp_bus.entry_count !== want.count)
                  report_mismatch($sformatf("entry_count %0d, expected %0d",
                                            rsp_bus.entry_count, want.count));
               if (rsp_bus.overflowed !== want.overflowed)
                  report_mismatch($sformatf("overflowed %b, expected %b",
                                            rsp_bus.overflowed, want.overflowed));
               if (rsp_bus.last_result !== want.last)
                  report_mismatch($sformatf("last_result %b, expected %b",
                                            rsp_bus.last_result, want.last));
            end
            stall = pick_gap();
         end
         if (stall > 0) begin
            rsp_bus.ready <= 1'b0;
            stall--;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   initial begin : watchdog
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("RESULT: ERROR");
      $finish;
   end

   initial begin : stimulus
      nlsp_pkg::op_type op;
      logic [15:0]      seq_number;
      logic [15:0]      loss_mask;
      logic [15:0]      window_base;
      int               roll;
      nack_result_type  answer;

      reset              <= 1'b1;
      req_bus.valid      <= 1'b0;
      req_bus.operation  <= nlsp_pkg::OP_INSERT;
      req_bus.seq_number <= 16'd0;
      req_bus.loss_mask  <= 16'd0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         answer = '{directed_rows[i].kind, 16'd0, 16'd0, directed_rows[i].count,
                    directed_rows[i].overflowed, 1'b1};
         send_command(directed_rows[i].op, directed_rows[i].seq_number,
                      directed_rows[i].loss_mask, directed_rows[i].known_answer, answer);
      end

      // Random phase. Numbers mostly land in a window that moves now and
      // then, so neighbors fall within one span and packs carry real masks.
      // Clears are rare enough that the list fills up from time to time.
      window_base = 16'($urandom);
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % 30 == 0)
            steady_run = ($urandom_range(0, 3) == 0);
         if ($urandom_range(0, 9) == 0)
            window_base = 16'($urandom);
         seq_number = window_base + 16'($urandom_range(0, 40));
         loss_mask  = 16'($urandom);
         roll = $urandom_range(0, 99);
         if (roll < 40) begin
            op = nlsp_pkg::OP_INSERT;
            if ($urandom_range(0, 4) == 0)
               seq_number = 16'($urandom);
         end else if (roll < 65) begin
            op = nlsp_pkg::OP_PAIR;
            if ($urandom_range(0, 1) == 0)
               loss_mask = loss_mask & 16'($urandom);
         end else if (roll < 90) begin
            op = nlsp_pkg::OP_PACK;
         end else begin
            op = nlsp_pkg::OP_CLEAR;
         end
         send_command(op, seq_number, loss_mask, 1'b0, answer);
      end
      req_bus.valid <= 1'b0;
      steady_run = 1'b0;

      while (expected_results.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
